[sv/sha384_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-384 package
// Round constants, initial hash values and the word-level helper functions
// shared by the front and back parts of the hash engine.
// ----------------------------------------------------------------------------
package sha384_pkg;

   localparam int WORD_W       = 64;
   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 80;
   localparam int DIGEST_WORDS = 6;

   typedef logic [WORD_W-1:0] word_type;

   // Entry pushed from the front part to the back part: one block word.
   typedef struct packed {
      word_type word;
      logic     last_word;   // last word of the final block of a message
   } blk_entry_type;

   localparam word_type SEED_H [8] = '{
      64'hcbbb9d5dc1059ed8, 64'h629a292a367cd507, 64'h9159015a3070dd17,
      64'h152fecd8f70e5939, 64'h67332667ffc00b31, 64'h8eb44a8768581511,
      64'hdb0c2e0d64f98fa7, 64'h47b5481dbefa4fa4
   };

   localparam word_type ROUND_K [ROUNDS] = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
   };

   localparam word_type MARK_WORD = 64'h8000000000000000;

   function automatic word_type rotr(input word_type x, input int n);
      rotr = (x >> n) | (x << (WORD_W - n));
   endfunction

   function automatic word_type big_sigma0(input word_type x);
      big_sigma0 = rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      big_sigma1 = rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      small_sigma0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      small_sigma1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
   endfunction

endpackage

[sv/sha384_front.sv]
// ----------------------------------------------------------------------------
// SHA-384 front part
// Accepts message beats, counts bytes and turns the last beat into the
// padded tail (mark, zero fill, bit length) as a stream of block words.
// ----------------------------------------------------------------------------
module sha384_front
   import sha384_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  word_type      req_message_word,
   input  logic [3:0]    req_valid_bytes,
   input  logic          req_last_word,
   output logic          push,
   output blk_entry_type push_data,
   input  logic          full
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MARK, ST_FILL, ST_LEN_HI, ST_LEN_LO
   } state_type;

   state_type   state_ff,  state_in;
   word_type    total_ff,  total_in;
   logic [3:0]  fill_ff,   fill_in;

   logic [3:0] vb;
   word_type   keep, padded;
   logic       accept;

   assign vb        = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE) || full;

   // Mask off unused bytes and place the mark for a short last word
   always_comb begin
      keep   = ~(64'hffffffffffffffff >> {vb[3:0], 3'b000});
      padded = (req_message_word & keep) | (MARK_WORD >> {vb[3:0], 3'b000});
   end

   // Word sequencer
   always_comb begin
      state_in  = state_ff;
      total_in  = total_ff;
      fill_in   = fill_ff;
      push      = 1'b0;
      push_data = '{word: '0, last_word: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               push = 1'b1;
               fill_in = fill_ff + 4'd1;
               if (!req_last_word) begin
                  total_in = total_ff + 64'd8;
                  push_data.word = req_message_word;
               end else begin
                  total_in = total_ff + {60'd0, vb};
                  if (vb == 4'd8) begin
                     push_data.word = req_message_word;
                     state_in = ST_MARK;
                  end else begin
                     push_data.word = padded;
                     state_in = ST_FILL;
                  end
               end
            end
         end
         ST_MARK: begin
            if (!full) begin
               push = 1'b1;
               push_data.word = MARK_WORD;
               fill_in = fill_ff + 4'd1;
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (fill_ff == 4'd14) begin
               state_in = ST_LEN_HI;
            end else if (!full) begin
               push = 1'b1;
               fill_in = fill_ff + 4'd1;
            end
         end
         ST_LEN_HI: begin
            if (!full) begin
               push = 1'b1;
               push_data.word = {61'd0, total_ff[63:61]};
               fill_in = fill_ff + 4'd1;
               state_in = ST_LEN_LO;
            end
         end
         ST_LEN_LO: begin
            if (!full) begin
               push = 1'b1;
               push_data.word = {total_ff[60:0], 3'b000};
               push_data.last_word = 1'b1;
               fill_in = 4'd0;
               total_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         total_ff <= '0;
         fill_ff  <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         fill_ff  <= fill_in;
      end
   end

endmodule

[sv/sha384_queue.sv]
// ----------------------------------------------------------------------------
// SHA-384 word queue
// Small FIFO of block words between the front and back parts.
// ----------------------------------------------------------------------------
module sha384_queue
   import sha384_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  blk_entry_type push_data,
   output logic          full,
   input  logic          pop,
   output blk_entry_type pop_data,
   output logic          empty
);

   localparam int DEPTH = 4;

   blk_entry_type mem_ff [DEPTH];
   logic [1:0]    wr_ff, rd_ff;
   logic [2:0]    cnt_ff;

   assign full     = (cnt_ff == 3'd4);
   assign empty    = (cnt_ff == 3'd0);
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push && !full) wr_ff <= wr_ff + 2'd1;
         if (pop && !empty) rd_ff <= rd_ff + 2'd1;
         cnt_ff <= cnt_ff + {2'd0, push && !full} - {2'd0, pop && !empty};
      end
      if (push && !full) mem_ff[wr_ff] <= push_data;
   end

endmodule

[sv/sha384_back.sv]
// ----------------------------------------------------------------------------
// SHA-384 back part
// Collects 16 block words, runs 80 rounds one per cycle, folds into the
// chain and emits the six digest beats after the final block.
// ----------------------------------------------------------------------------
module sha384_back
   import sha384_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          empty,
   input  blk_entry_type pop_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output word_type      rsp_digest_word,
   output logic [2:0]    rsp_word_index,
   output logic          rsp_digest_done
);

   typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT} state_type;

   state_type  state_ff;
   word_type   chain_ff [8];
   word_type   work_ff  [8];
   word_type   win_ff   [BLOCK_WORDS];
   logic [3:0] fill_ff;
   logic [6:0] round_ff;
   logic       final_ff;
   logic [2:0] idx_ff;

   word_type w, t1, t2, ch, maj;

   assign pop = (state_ff == ST_LOAD) && !empty;

   // Round datapath; the window shifts so win_ff[0] is w[t] before round 16 and w[t-16] from then on
   always_comb begin
      if (round_ff < 7'd16) w = win_ff[0];
      else w = win_ff[0] + small_sigma0(win_ff[1]) + win_ff[9] + small_sigma1(win_ff[14]);
      ch  = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^ (work_ff[1] & work_ff[2]);
      t1  = work_ff[7] + big_sigma1(work_ff[4]) + ch + ROUND_K[round_ff] + w;
      t2  = big_sigma0(work_ff[0]) + maj;
   end

   assign rsp_valid       = (state_ff == ST_EMIT);
   assign rsp_digest_word = chain_ff[idx_ff];
   assign rsp_word_index  = idx_ff;
   assign rsp_digest_done = (idx_ff == 3'd5);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         fill_ff  <= '0;
         round_ff <= '0;
         final_ff <= 1'b0;
         idx_ff   <= '0;
         for (int i = 0; i < 8; i++) chain_ff[i] <= SEED_H[i];
      end else begin
         case (state_ff)
            ST_LOAD: begin
               if (!empty) begin
                  for (int i = 0; i < BLOCK_WORDS - 1; i++) win_ff[i] <= win_ff[i+1];
                  win_ff[BLOCK_WORDS-1] <= pop_data.word;
                  fill_ff  <= fill_ff + 4'd1;
                  final_ff <= pop_data.last_word;
                  if (fill_ff == 4'd15) begin
                     state_ff <= ST_ROUND;
                     round_ff <= '0;
                     for (int i = 0; i < 8; i++) work_ff[i] <= chain_ff[i];
                  end
               end
            end
            ST_ROUND: begin
               for (int i = 0; i < BLOCK_WORDS - 1; i++) win_ff[i] <= win_ff[i+1];
               win_ff[BLOCK_WORDS-1] <= w;
               work_ff[7] <= work_ff[6];
               work_ff[6] <= work_ff[5];
               work_ff[5] <= work_ff[4];
               work_ff[4] <= work_ff[3] + t1;
               work_ff[3] <= work_ff[2];
               work_ff[2] <= work_ff[1];
               work_ff[1] <= work_ff[0];
               work_ff[0] <= t1 + t2;
               round_ff <= round_ff + 7'd1;
               if (round_ff == 7'(ROUNDS - 1)) state_ff <= ST_FOLD;
            end
            ST_FOLD: begin
               for (int i = 0; i < 8; i++) chain_ff[i] <= chain_ff[i] + work_ff[i];
               idx_ff   <= '0;
               state_ff <= final_ff ? ST_EMIT : ST_LOAD;
            end
            ST_EMIT: begin
               if (!rsp_stall) begin
                  if (idx_ff == 3'd5) begin
                     for (int i = 0; i < 8; i++) chain_ff[i] <= SEED_H[i];
                     final_ff <= 1'b0;
                     state_ff <= ST_LOAD;
                  end
                  idx_ff <= idx_ff + 3'd1;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end

endmodule

[sv/sha384_hash_engine.sv]
// ----------------------------------------------------------------------------
// SHA-384 hash engine
// Usage: message beats enter on req_ (valid/stall): message_word big-endian,
// valid_bytes (8 except on the last beat), last_word on the final beat.
// The front part counts bytes and builds the padding; a four-entry word
// queue feeds the back part, which compresses each 128-byte block with one
// SHA-512 round per cycle between loading its words and folding into the chain.
// The front part keeps taking beats while a block is compressed, until the
// queue fills; the pace is set by the single round unit. After the last
// beat the padding words (up to one extra block) are compressed, then six
// digest beats leave on rsp_ with word_index 0..5 and digest_done on the
// sixth.
// Reset (synchronous, active high) reseeds the chain and empties the queue.
// While rsp_stall is high the current digest beat holds, the back part
// waits, and the queue fills until req_stall rises.
// ----------------------------------------------------------------------------
module sha384_hash_engine
   import sha384_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [63:0] req_message_word,
   input  logic [3:0] req_valid_bytes,
   input  logic       req_last_word,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [63:0] rsp_digest_word,
   output logic [2:0] rsp_word_index,
   output logic       rsp_digest_done
);

   logic          push, full, pop, empty;
   blk_entry_type push_data, pop_data;

   sha384_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_message_word,
      .req_valid_bytes, .req_last_word, .push, .push_data, .full
   );

   sha384_queue u_queue (
      .clock, .reset, .push, .push_data, .full, .pop, .pop_data, .empty
   );

   sha384_back u_back (
      .clock, .reset, .empty, .pop_data, .pop, .rsp_valid, .rsp_stall,
      .rsp_digest_word, .rsp_word_index, .rsp_digest_done
   );

   // Done flag only on the sixth digest beat
   a_done_idx: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_digest_done == (rsp_word_index == 3'd5)))
      else $error("digest_done out of place");

   // Digest index advances by one after each taken beat inside a digest
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_digest_done) |=>
      (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest index skipped");

   // Never push into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue overflow");

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SHA-384 hash engine testbench
// Drives message beats with random gaps, predicts each digest with a local
// SHA-384 model and checks every digest beat field by field, in order.
// ----------------------------------------------------------------------------
module testbench
   import sha384_pkg::*;
;

   typedef struct {
      logic [63:0] digest_word;
      logic [2:0]  word_index;
      logic        digest_done;
   } digest_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [63:0] req_message_word = '0;
   logic [3:0]  req_valid_bytes = '0;
   logic        req_last_word = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_digest_done;

   // local copy of the hash state
   logic [63:0] chain_h [8];
   logic [63:0] blk_buf [16];
   logic [63:0] msg_bytes;
   int          blk_fill;

   digest_beat_type digest_queue[$];
   int  errors = 0;
   int  cycle_count = 0;
   bit  hold_off = 1'b0;
   bit  random_stall = 1'b1;

   sha384_hash_engine dut (.*);

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 600000) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [63:0] ror(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   // one SHA-512 compression over blk_buf
   function automatic void compress_blk();
      logic [63:0] v [8];
      logic [63:0] w [80];
      logic [63:0] t1, t2;
      for (int i = 0; i < 8; i++) v[i] = chain_h[i];
      for (int t = 0; t < 80; t++) begin
         if (t < 16) w[t] = blk_buf[t];
         else w[t] = w[t-16] + (ror(w[t-15],1) ^ ror(w[t-15],8) ^ (w[t-15] >> 7))
                   + w[t-7] + (ror(w[t-2],19) ^ ror(w[t-2],61) ^ (w[t-2] >> 6));
         t1 = v[7] + (ror(v[4],14) ^ ror(v[4],18) ^ ror(v[4],41))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[t] + w[t];
         t2 = (ror(v[0],28) ^ ror(v[0],34) ^ ror(v[0],39))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain_h[i] += v[i];
   endfunction

   function automatic void push_blk_word(logic [63:0] w);
      blk_buf[blk_fill] = w;
      blk_fill++;
      if (blk_fill == 16) begin
         compress_blk();
         blk_fill = 0;
      end
   endfunction

   function automatic void reseed();
      for (int i = 0; i < 8; i++) chain_h[i] = SEED_H[i];
      msg_bytes = '0;
      blk_fill = 0;
   endfunction

   // fold one accepted beat into the hash; queue the digest on the last one
   function automatic void predict_digest(logic [63:0] word, logic [3:0] vb, logic last);
      int n;
      logic [63:0] keep;
      digest_beat_type d;
      n = (vb > 8) ? 8 : vb;
      if (!last) begin
         msg_bytes += 8;
         push_blk_word(word);
         return;
      end
      msg_bytes += n;
      if (n == 0) push_blk_word(MARK_WORD);
      else if (n == 8) begin
         push_blk_word(word);
         push_blk_word(MARK_WORD);
      end else begin
         keep = ~64'd0 << (64 - 8 * n);
         push_blk_word((word & keep) | (64'h80 << (56 - 8 * n)));
      end
      if (blk_fill > 14) while (blk_fill != 0) push_blk_word('0);
      while (blk_fill < 14) push_blk_word('0);
      push_blk_word(msg_bytes >> 61);
      push_blk_word(msg_bytes << 3);
      for (int k = 0; k < 6; k++) begin
         d.digest_word = chain_h[k];
         d.word_index  = k[2:0];
         d.digest_done = (k == 5);
         digest_queue.push_back(d);
      end
      reseed();
   endfunction

   // send one beat, with a random gap in front; valid drops after a last beat
   task automatic send_beat(logic [63:0] word, logic [3:0] vb, logic last);
      int gap;
      gap = $urandom_range(0, 14) * $urandom_range(0, 1);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_message_word <= word;
      req_valid_bytes <= vb;
      req_last_word <= last;
      do @(posedge clock); while (req_stall);
      predict_digest(word, vb, last);
      if (last) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_message(int words, logic [3:0] last_vb);
      for (int i = 0; i < words - 1; i++)
         send_beat({$urandom, $urandom}, (($urandom_range(0, 9) == 0) ?
                   4'($urandom_range(0, 15)) : 4'd8), 1'b0);
      send_beat({$urandom, $urandom}, last_vb, 1'b1);
   endtask

   task automatic wait_drain();
      while (digest_queue.size() != 0) @(negedge clock);
      repeat (250) @(negedge clock);
   endtask

   // receiver stall pattern
   always @(negedge clock) begin
      if (hold_off) rsp_stall <= 1'b1;
      else if (random_stall) rsp_stall <= ($urandom_range(0, 3) == 0);
      else rsp_stall <= 1'b0;
   end

   // digest beat checker
   always @(posedge clock) begin
      digest_beat_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (digest_queue.size() == 0) begin
            $display("%0t: unexpected digest beat %h", $time, rsp_digest_word);
            errors++;
         end else begin
            e = digest_queue.pop_front();
            if (rsp_digest_word !== e.digest_word) begin
               $display("%0t: digest_word exp %h got %h", $time, e.digest_word,
                        rsp_digest_word);
               errors++;
            end
            if (rsp_word_index !== e.word_index) begin
               $display("%0t: word_index exp %0d got %0d", $time, e.word_index,
                        rsp_word_index);
               errors++;
            end
            if (rsp_digest_done !== e.digest_done) begin
               $display("%0t: digest_done exp %0d got %0d", $time, e.digest_done,
                        rsp_digest_done);
               errors++;
            end
         end
      end
   end

   // edge cases: empty message, all-ones and all-zero words, every tail size,
   // oversize byte counts, mark near the block end
   task automatic test_directed();
      send_beat('0, 4'd0, 1'b1);
      send_beat(64'h6162638000000000, 4'd3, 1'b1);
      send_beat('1, 4'd15, 1'b1);
      send_beat('1, 4'd5, 1'b0);
      send_beat('1, 4'd7, 1'b1);
      for (int n = 1; n <= 8; n++) send_message(1, 4'(n));
      send_message(14, 4'd8);
      send_message(15, 4'd3);
      send_message(16, 4'd0);
   endtask

   // random messages, mostly short, a few several blocks long
   task automatic test_random();
      int sent = 0;
      int len;
      while (sent < 20) begin
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 34) : $urandom_range(1, 6);
         send_message(len, 4'($urandom_range(0, 15)));
         sent += len;
      end
   endtask

   // receiver holds off for a counted stretch while two messages pile up,
   // then the sender waits for every digest
   task automatic test_backpressure();
      fork
         begin
            hold_off = 1'b1;
            repeat (600) @(negedge clock);
            hold_off = 1'b0;
         end
         begin
            send_message(20, 4'd4);
            send_message(8, 4'd8);
         end
      join
      wait_drain();
      random_stall = 1'b0;
      send_message(3, 4'd2);
      wait_drain();
      random_stall = 1'b1;
   endtask

   initial begin
      reseed();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_backpressure();
      test_random();
      wait_drain();
      if (errors == 0 && digest_queue.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end
endmodule
